// ===== sv/spcb_pkg.sv =====
package spcb_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_AREA_LEFT   = 2'd0,
    CFG_AREA_TOP    = 2'd1,
    CFG_AREA_WIDTH  = 2'd2,
    CFG_AREA_HEIGHT = 2'd3
  } cfg_idx_e;

  // Request kinds.
  typedef enum logic {
    REQ_BEGIN = 1'b0,
    REQ_PIECE = 1'b1
  } req_type_e;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW  = 15;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Mode bits latched by a begin transaction.
  localparam int unsigned ModeClipArea = 0;
  localparam int unsigned ModeWindow   = 1;

  // Offset value that selects the layer position instead.
  localparam logic signed [CoordW-1:0] OffsetUseLayer = 16'sd1000;

  localparam logic [SizeW-1:0] AreaWidthReset  = 15'd320;
  localparam logic [SizeW-1:0] AreaHeightReset = 15'd200;

  typedef struct packed {
    logic                     req_type;
    logic [1:0]               mode;
    logic signed [CoordW-1:0] dest_x;
    logic signed [CoordW-1:0] dest_y;
    logic [7:0]               pict_code;
    logic signed [CoordW-1:0] delta_x;
    logic signed [CoordW-1:0] delta_y;
    logic signed [CoordW-1:0] src_left;
    logic signed [CoordW-1:0] src_right;
    logic signed [CoordW-1:0] src_top;
    logic signed [CoordW-1:0] src_bottom;
  } in_item_t;

  typedef struct packed {
    logic                     visible;
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_src_left;
    logic signed [CoordW-1:0] out_src_top;
    logic signed [CoordW-1:0] out_width;
    logic signed [CoordW-1:0] out_height;
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_top;
    logic signed [CoordW-1:0] box_right;
    logic signed [CoordW-1:0] box_bottom;
    logic                     box_valid;
  } out_item_t;

  // Held input transaction with the picture-code extended destination.
  typedef struct packed {
    in_item_t                 item;
    logic signed [CoordW-1:0] ext_x;
    logic signed [CoordW-1:0] ext_y;
  } held_item_t;

  // Clip window handed to one axis clipper.
  typedef struct packed {
    logic                     en;
    logic                     excl;
    logic signed [CoordW-1:0] low;
    logic signed [CoordW-1:0] lim;
  } clip_ctl_t;

endpackage

// ===== sv/spcb_in_stage.sv =====
module spcb_in_stage
  import spcb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  in_item_t   item_i,
  output held_item_t held_o
);

  logic [8:0]               hx;
  logic [8:0]               hy;
  logic signed [CoordW-1:0] ext_x;
  logic signed [CoordW-1:0] ext_y;
  held_item_t               held_q;

  // Picture code bits move the destination away from zero in steps of 128.
  always_comb begin
    hx = {item_i.pict_code[7:6], 7'd0};
    hy = {item_i.pict_code[5:4], 7'd0};
    if (item_i.dest_x[CoordW-1]) begin
      ext_x = item_i.dest_x - $signed({7'd0, hx});
    end else begin
      ext_x = item_i.dest_x + $signed({7'd0, hx});
    end
    if (item_i.dest_y[CoordW-1]) begin
      ext_y = item_i.dest_y - $signed({7'd0, hy});
    end else begin
      ext_y = item_i.dest_y + $signed({7'd0, hy});
    end
  end

  // Input register; it loads whenever a transaction is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (load_i) begin
      held_q.item  <= item_i;
      held_q.ext_x <= ext_x;
      held_q.ext_y <= ext_y;
    end
  end

  assign held_o = held_q;

endmodule

// ===== sv/spcb_axis_clip.sv =====
module spcb_axis_clip
  import spcb_pkg::*;
(
  input  clip_ctl_t                ctl_i,
  input  logic signed [CoordW-1:0] pos_i,
  input  logic signed [CoordW-1:0] lo_i,
  input  logic signed [CoordW-1:0] hi_i,
  output logic signed [CoordW-1:0] pos_o,
  output logic signed [CoordW-1:0] lo_o,
  output logic signed [CoordW-1:0] hi_o
);

  logic signed [CoordW-1:0] pos_c;
  logic signed [CoordW-1:0] lo_c;
  logic signed [CoordW-1:0] far;
  logic                     over;

  always_comb begin
    // Low edge: move the destination in and skip source columns.
    if (ctl_i.en && (pos_i < ctl_i.low)) begin
      pos_c = ctl_i.low;
      lo_c  = lo_i + ctl_i.low - pos_i;
    end else begin
      pos_c = pos_i;
      lo_c  = lo_i;
    end

    // High edge: trim the source end by the overhang.
    far = pos_c + hi_i - lo_c;
    if (ctl_i.excl) begin
      over = (far >= ctl_i.lim);
    end else begin
      over = (far > ctl_i.lim);
    end

    pos_o = pos_c;
    lo_o  = lo_c;
    if (ctl_i.en && (lo_c <= hi_i) && over) begin
      hi_o = hi_i - far + ctl_i.lim - $signed({{(CoordW-1){1'b0}}, ctl_i.excl});
    end else begin
      hi_o = hi_i;
    end
  end

endmodule

// ===== sv/sprite_piece_clip_and_bound_core.sv =====
// Sprite piece clipper with redraw box tracking.
//
// Input channel: in_valid_i / in_stall_o carry one transaction per item, a
// begin-frame request or a frame piece. Output channel: out_valid_o /
// out_stall_i return exactly one result per input transaction, in order.
// Configuration: cfg_we_i writes cfg_data_i to the area register chosen by
// cfg_idx_i at the clock edge; write only while the block is idle.
//
// From input acceptance to output, a transaction passes the input register,
// which loads at the accepting edge, and the output register, which the clip
// and box logic loads when the held transaction moves on; the receiver takes
// the result from there. Throughput is one transaction per cycle while the
// receiver does not stall; the box update of one piece commits as the piece
// moves on, so it is ready for the next piece.
//
// Reset clears the frame mode, offsets, layer position and redraw box (box
// empty) and loads the area registers with 0, 0, 320 and 200. While the
// receiver stalls, the result holds and the input register still takes one
// more transaction before in_stall_o rises.
module sprite_piece_clip_and_bound_core
  import spcb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Handshake and pipeline valid bits.
  logic       hold_valid_q;
  logic       out_valid_q;
  logic       advance;
  logic       accept;
  logic       fire;
  held_item_t held;
  out_item_t  out_q;
  out_item_t  out_d;

  // Area configuration.
  logic signed [CoordW-1:0] area_left_q;
  logic signed [CoordW-1:0] area_top_q;
  logic [SizeW-1:0]         area_width_q;
  logic [SizeW-1:0]         area_height_q;

  // Frame state.
  logic [1:0]               frame_mode_q, frame_mode_d;
  logic signed [CoordW-1:0] offset_x_q, offset_x_d;
  logic signed [CoordW-1:0] offset_y_q, offset_y_d;
  logic signed [CoordW-1:0] layer_x_q, layer_x_d;
  logic signed [CoordW-1:0] layer_y_q, layer_y_d;
  logic signed [CoordW-1:0] box_left_q, box_left_d;
  logic signed [CoordW-1:0] box_top_q, box_top_d;
  logic signed [CoordW-1:0] box_right_q, box_right_d;
  logic signed [CoordW-1:0] box_bottom_q, box_bottom_d;
  logic                     box_valid_q, box_valid_d;

  // Datapath.
  logic signed [CoordW-1:0] area_right_x;
  logic signed [CoordW-1:0] area_bottom_x;
  logic signed [CoordW-1:0] pos_x, pos_y;
  logic signed [CoordW-1:0] cx, cy, cl, cr, ct, cb;
  logic signed [CoordW-1:0] ex, ey;
  logic                     is_piece;
  logic                     vis;
  clip_ctl_t                ctl_x, ctl_y;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = hold_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = hold_valid_q && advance;

  spcb_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .item_i (in_data_i),
    .held_o (held)
  );

  // Area edges, exclusive on the far side.
  assign area_right_x  = area_left_q + $signed({1'b0, area_width_q});
  assign area_bottom_x = area_top_q + $signed({1'b0, area_height_q});

  // Destination plus frame offset or layer position.
  always_comb begin
    if (offset_x_q == OffsetUseLayer) begin
      pos_x = held.ext_x + layer_x_q;
    end else begin
      pos_x = held.ext_x + offset_x_q;
    end
    if (offset_y_q == OffsetUseLayer) begin
      pos_y = held.ext_y + layer_y_q;
    end else begin
      pos_y = held.ext_y + offset_y_q;
    end
  end

  // Clip limits: the area when its bit is set, else the redraw window; no clipping when neither mode bit is set.
  always_comb begin
    ctl_x.en   = frame_mode_q[ModeClipArea] || frame_mode_q[ModeWindow];
    ctl_x.excl = frame_mode_q[ModeClipArea];
    ctl_y.en   = ctl_x.en;
    ctl_y.excl = ctl_x.excl;
    if (frame_mode_q[ModeClipArea]) begin
      ctl_x.low = area_left_q;
      ctl_x.lim = area_right_x;
      ctl_y.low = area_top_q;
      ctl_y.lim = area_bottom_x;
    end else begin
      ctl_x.low = box_left_q;
      ctl_x.lim = box_right_q;
      ctl_y.low = box_top_q;
      ctl_y.lim = box_bottom_q;
    end
  end

  spcb_axis_clip u_clip_x (
    .ctl_i (ctl_x),
    .pos_i (pos_x),
    .lo_i  (held.item.src_left),
    .hi_i  (held.item.src_right),
    .pos_o (cx),
    .lo_o  (cl),
    .hi_o  (cr)
  );

  spcb_axis_clip u_clip_y (
    .ctl_i (ctl_y),
    .pos_i (pos_y),
    .lo_i  (held.item.src_top),
    .hi_i  (held.item.src_bottom),
    .pos_o (cy),
    .lo_o  (ct),
    .hi_o  (cb)
  );

  assign is_piece = (held.item.req_type == REQ_PIECE);
  assign vis      = is_piece && (cl <= cr) && (ct <= cb);
  assign ex       = cx + cr - cl;
  assign ey       = cy + cb - ct;

  // Next frame state and redraw box.
  always_comb begin
    frame_mode_d = frame_mode_q;
    offset_x_d   = offset_x_q;
    offset_y_d   = offset_y_q;
    layer_x_d    = layer_x_q;
    layer_y_d    = layer_y_q;
    box_left_d   = box_left_q;
    box_top_d    = box_top_q;
    box_right_d  = box_right_q;
    box_bottom_d = box_bottom_q;
    box_valid_d  = box_valid_q;
    if (!is_piece) begin
      frame_mode_d = held.item.mode;
      layer_x_d    = held.item.dest_x;
      layer_y_d    = held.item.dest_y;
      offset_x_d   = held.item.delta_x;
      offset_y_d   = held.item.delta_y;
      if (held.item.mode[ModeWindow]) begin
        // Narrow the window to the area.
        if (area_left_q > box_left_q) box_left_d = area_left_q;
        if (area_top_q > box_top_q) box_top_d = area_top_q;
        if ((area_right_x - 16'sd1) < box_right_q) box_right_d = area_right_x - 16'sd1;
        if ((area_bottom_x - 16'sd1) < box_bottom_q) begin
          box_bottom_d = area_bottom_x - 16'sd1;
        end
      end else begin
        box_valid_d = 1'b0;
      end
    end else if (vis && !frame_mode_q[ModeWindow]) begin
      // Grow the box by the visible piece, or start it.
      box_valid_d = 1'b1;
      if (!box_valid_q) begin
        box_left_d   = cx;
        box_top_d    = cy;
        box_right_d  = ex;
        box_bottom_d = ey;
      end else begin
        if (cx < box_left_q) box_left_d = cx;
        if (cy < box_top_q) box_top_d = cy;
        if (ex > box_right_q) box_right_d = ex;
        if (ey > box_bottom_q) box_bottom_d = ey;
      end
    end
  end

  // Result assembly.
  always_comb begin
    out_d.visible      = vis;
    out_d.out_x        = vis ? cx : '0;
    out_d.out_y        = vis ? cy : '0;
    out_d.out_src_left = vis ? cl : '0;
    out_d.out_src_top  = vis ? ct : '0;
    out_d.out_width    = vis ? (cr - cl + 16'sd1) : '0;
    out_d.out_height   = vis ? (cb - ct + 16'sd1) : '0;
    out_d.box_left     = box_left_d;
    out_d.box_top      = box_top_d;
    out_d.box_right    = box_right_d;
    out_d.box_bottom   = box_bottom_d;
    out_d.box_valid    = box_valid_d;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        hold_valid_q <= 1'b1;
      end else if (advance) begin
        hold_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= hold_valid_q;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  // Frame state commits when a transaction leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q <= '0;
      offset_x_q   <= '0;
      offset_y_q   <= '0;
      layer_x_q    <= '0;
      layer_y_q    <= '0;
      box_left_q   <= '0;
      box_top_q    <= '0;
      box_right_q  <= '0;
      box_bottom_q <= '0;
      box_valid_q  <= 1'b0;
    end else if (fire) begin
      frame_mode_q <= frame_mode_d;
      offset_x_q   <= offset_x_d;
      offset_y_q   <= offset_y_d;
      layer_x_q    <= layer_x_d;
      layer_y_q    <= layer_y_d;
      box_left_q   <= box_left_d;
      box_top_q    <= box_top_d;
      box_right_q  <= box_right_d;
      box_bottom_q <= box_bottom_d;
      box_valid_q  <= box_valid_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q   <= '0;
      area_top_q    <= '0;
      area_width_q  <= AreaWidthReset;
      area_height_q <= AreaHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AREA_LEFT:   area_left_q   <= cfg_data_i;
        CFG_AREA_TOP:    area_top_q    <= cfg_data_i;
        CFG_AREA_WIDTH:  area_width_q  <= cfg_data_i[SizeW-1:0];
        CFG_AREA_HEIGHT: area_height_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sprite_piece_clip_and_bound_core_tb.sv =====
module sprite_piece_clip_and_bound_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spcb_pkg::*;

  typedef logic signed [CoordW-1:0] crd_t;

  // Clock, reset and the block's channels.
  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  in_item_t           in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  // Predicted block state: area registers, frame latches and redraw box.
  crd_t             area_x0  = '0;
  crd_t             area_y0  = '0;
  logic [SizeW-1:0] area_w   = AreaWidthReset;
  logic [SizeW-1:0] area_h   = AreaHeightReset;
  logic [1:0]       mode_lat = '0;
  crd_t             ofs_x    = '0;
  crd_t             ofs_y    = '0;
  crd_t             lay_x    = '0;
  crd_t             lay_y    = '0;
  crd_t             dirty_l  = '0;
  crd_t             dirty_t  = '0;
  crd_t             dirty_r  = '0;
  crd_t             dirty_b  = '0;
  logic             dirty_ok = 1'b0;

  // Clipped results still owed by the block, oldest first.
  out_item_t   pending_results[$];
  out_item_t   want_res;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned bad_results  = 0;
  int unsigned areas_used   = 0;
  bit          gaps_on      = 1'b0;

  sprite_piece_clip_and_bound_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Clip one axis against a low limit and a high limit, the high limit being
  // exclusive for the area and inclusive for the redraw window.
  function automatic void clip_span(inout crd_t pos, inout crd_t lo, inout crd_t hi,
                                    input crd_t lo_lim, input crd_t hi_lim,
                                    input logic excl);
    crd_t far_end;
    crd_t over;
    if (pos < lo_lim) begin
      lo  = lo + (lo_lim - pos);
      pos = lo_lim;
    end
    if (lo <= hi) begin
      far_end = pos + hi - lo;
      if (excl ? (far_end >= hi_lim) : (far_end > hi_lim)) begin
        over = far_end - hi_lim + (excl ? 16'sd1 : 16'sd0);
        hi   = hi - over;
      end
    end
  endfunction

  // Work out the result of one transaction and advance the predicted state.
  function automatic out_item_t predict_clip(in_item_t it);
    out_item_t res;
    crd_t dx, dy, sl, sr, st, sb, hx, hy, aw, ah, x_end, y_end;
    res = '0;
    aw  = {1'b0, area_w};
    ah  = {1'b0, area_h};
    if (it.req_type == REQ_BEGIN) begin
      mode_lat = it.mode;
      lay_x    = it.dest_x;
      lay_y    = it.dest_y;
      ofs_x    = it.delta_x;
      ofs_y    = it.delta_y;
      if (it.mode[ModeWindow]) begin
        // The window is narrowed to the area even while the box is empty.
        x_end = area_x0 + aw - 16'sd1;
        y_end = area_y0 + ah - 16'sd1;
        if (area_x0 > dirty_l) dirty_l = area_x0;
        if (area_y0 > dirty_t) dirty_t = area_y0;
        if (x_end < dirty_r) dirty_r = x_end;
        if (y_end < dirty_b) dirty_b = y_end;
      end else begin
        dirty_ok = 1'b0;
      end
    end else begin
      // Picture code high bits push the destination away from zero.
      hx = {7'd0, it.pict_code[7:6], 7'd0};
      hy = {7'd0, it.pict_code[5:4], 7'd0};
      dx = it.dest_x;
      dy = it.dest_y;
      dx = (dx >= 16'sd0) ? dx + hx : dx - hx;
      dy = (dy >= 16'sd0) ? dy + hy : dy - hy;
      dx = dx + ((ofs_x == OffsetUseLayer) ? lay_x : ofs_x);
      dy = dy + ((ofs_y == OffsetUseLayer) ? lay_y : ofs_y);
      sl = it.src_left;
      sr = it.src_right;
      st = it.src_top;
      sb = it.src_bottom;
      if (mode_lat[ModeClipArea]) begin
        x_end = area_x0 + aw;
        y_end = area_y0 + ah;
        clip_span(dx, sl, sr, area_x0, x_end, 1'b1);
        clip_span(dy, st, sb, area_y0, y_end, 1'b1);
      end else if (mode_lat[ModeWindow]) begin
        clip_span(dx, sl, sr, dirty_l, dirty_r, 1'b0);
        clip_span(dy, st, sb, dirty_t, dirty_b, 1'b0);
      end
      if (sl <= sr && st <= sb) begin
        x_end            = dx + (sr - sl);
        y_end            = dy + (sb - st);
        res.visible      = 1'b1;
        res.out_x        = dx;
        res.out_y        = dy;
        res.out_src_left = sl;
        res.out_src_top  = st;
        res.out_width    = sr - sl + 16'sd1;
        res.out_height   = sb - st + 16'sd1;
        // Outside window mode the visible piece grows the redraw box.
        if (!mode_lat[ModeWindow]) begin
          if (!dirty_ok) begin
            dirty_l  = dx;
            dirty_t  = dy;
            dirty_r  = x_end;
            dirty_b  = y_end;
            dirty_ok = 1'b1;
          end else begin
            if (dx < dirty_l) dirty_l = dx;
            if (dy < dirty_t) dirty_t = dy;
            if (x_end > dirty_r) dirty_r = x_end;
            if (y_end > dirty_b) dirty_b = y_end;
          end
        end
      end
    end
    res.box_left   = dirty_l;
    res.box_top    = dirty_t;
    res.box_right  = dirty_r;
    res.box_bottom = dirty_b;
    res.box_valid  = dirty_ok;
    return res;
  endfunction

  function automatic string show_result(out_item_t r);
    return $sformatf("vis=%0d x=%0d y=%0d sl=%0d st=%0d w=%0d h=%0d box=(%0d,%0d,%0d,%0d) ok=%0d",
                     r.visible, r.out_x, r.out_y, r.out_src_left, r.out_src_top,
                     r.out_width, r.out_height, r.box_left, r.box_top, r.box_right,
                     r.box_bottom, r.box_valid);
  endfunction

  // Every accepted input transaction owes one result.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) pending_results.push_back(predict_clip(in_data));
  end

  // Compare each accepted output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d arrived with nothing expected: %s", results_seen,
                   show_result(out_data));
      end else begin
        want_res = pending_results.pop_front();
        if (out_data !== want_res) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("result %0d differs", results_seen);
            $display("  expected: %s", show_result(want_res));
            $display("  actual:   %s", show_result(out_data));
          end
        end
      end
    end
  end

  // The receiver stalls in short random bursts while gaps are enabled.
  initial begin
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Random bits for every field; builders overwrite the fields they care about.
  function automatic in_item_t raw_item();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t begin_item(logic [1:0] m, crd_t lx, crd_t ly,
                                          crd_t ox, crd_t oy);
    in_item_t it;
    it          = raw_item();
    it.req_type = REQ_BEGIN;
    it.mode     = m;
    it.dest_x   = lx;
    it.dest_y   = ly;
    it.delta_x  = ox;
    it.delta_y  = oy;
    return it;
  endfunction

  function automatic in_item_t piece_item(crd_t x, crd_t y, logic [7:0] pc,
                                          crd_t sl, crd_t sr, crd_t st, crd_t sb);
    in_item_t it;
    it            = raw_item();
    it.req_type   = REQ_PIECE;
    it.dest_x     = x;
    it.dest_y     = y;
    it.pict_code  = pc;
    it.src_left   = sl;
    it.src_right  = sr;
    it.src_top    = st;
    it.src_bottom = sb;
    return it;
  endfunction

  function automatic crd_t pick_offset();
    case ($urandom_range(0, 5))
      0:       return OffsetUseLayer;
      1:       return crd_t'($urandom);
      2:       return 16'sd0;
      default: return crd_t'($urandom_range(0, 120)) - 16'sd60;
    endcase
  endfunction

  function automatic in_item_t rand_begin();
    return begin_item(2'($urandom_range(0, 3)),
                      crd_t'($urandom_range(0, 200)) - 16'sd100,
                      crd_t'($urandom_range(0, 200)) - 16'sd100,
                      pick_offset(), pick_offset());
  endfunction

  // Mostly pieces around the area edges, with some fully random ones.
  function automatic in_item_t rand_piece();
    in_item_t it;
    it          = raw_item();
    it.req_type = REQ_PIECE;
    if ($urandom_range(0, 9) != 0) begin
      it.dest_x     = area_x0 + crd_t'($urandom_range(0, 450)) - 16'sd150;
      it.dest_y     = area_y0 + crd_t'($urandom_range(0, 450)) - 16'sd150;
      if ($urandom_range(0, 2) != 0) it.pict_code[7:4] = 4'd0;
      it.src_left   = crd_t'($urandom_range(0, 300)) - 16'sd50;
      it.src_right  = it.src_left + crd_t'($urandom_range(0, 120)) - 16'sd4;
      it.src_top    = crd_t'($urandom_range(0, 300)) - 16'sd50;
      it.src_bottom = it.src_top + crd_t'($urandom_range(0, 120)) - 16'sd4;
    end
    return it;
  endfunction

  // Present one transaction, after an optional gap, and hold it until taken.
  task automatic send_item(in_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_AREA_LEFT:   area_x0 = val;
      CFG_AREA_TOP:    area_y0 = val;
      CFG_AREA_WIDTH:  area_w  = val[SizeW-1:0];
      CFG_AREA_HEIGHT: area_h  = val[SizeW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Area changes only happen with the block idle.
  task automatic set_area(logic [CfgW-1:0] x0, logic [CfgW-1:0] y0,
                          logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    drain();
    write_reg(CFG_AREA_LEFT, x0);
    write_reg(CFG_AREA_TOP, y0);
    write_reg(CFG_AREA_WIDTH, w);
    write_reg(CFG_AREA_HEIGHT, h);
    areas_used++;
  endtask

  // Frames of a begin transaction and a few pieces, with occasional noise.
  task automatic run_frames(int unsigned quota, bit allow_gaps);
    int unsigned stop_at;
    int unsigned pieces;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      gaps_on = allow_gaps && ($urandom_range(0, 4) != 0);
      send_item(rand_begin());
      pieces = $urandom_range(1, 12);
      for (int unsigned k = 0; k < pieces; k++)
        send_item(($urandom_range(0, 11) == 0) ? raw_item() : rand_piece());
    end
  endtask

  // A piece arriving before any begin uses the reset frame state.
  task automatic test_piece_before_begin();
    send_item(piece_item(10, 20, 8'h00, 0, 15, 0, 7));
  endtask

  // Each clip mode with a piece that hangs over the left and bottom edges.
  task automatic test_frame_modes();
    for (int m = 0; m < 4; m++) begin
      send_item(begin_item(2'(m), 3, 4, 5, -7));
      send_item(piece_item(-20, 190, 8'h0F, 2, 40, 1, 30));
    end
  endtask

  // Window mode right after the box was emptied.
  task automatic test_empty_window();
    send_item(begin_item(2'd0, 0, 0, 0, 0));
    send_item(begin_item(2'd2, 0, 0, 0, 0));
    send_item(piece_item(50, 50, 8'h00, 0, 9, 0, 9));
  endtask

  // Offset 1000 selects the layer position, one axis at a time too.
  task automatic test_layer_offset();
    send_item(begin_item(2'd1, -40, 55, OffsetUseLayer, OffsetUseLayer));
    send_item(piece_item(30, 30, 8'h00, 0, 20, 0, 20));
    send_item(begin_item(2'd0, 7, 9, OffsetUseLayer, 999));
    send_item(piece_item(30, 30, 8'h00, 0, 20, 0, 20));
  endtask

  // Picture code extension for positive, zero and negative destinations.
  task automatic test_pict_extension();
    send_item(begin_item(2'd0, 0, 0, 0, 0));
    send_item(piece_item(5, 5, 8'hF0, 0, 3, 0, 3));
    send_item(piece_item(-5, -5, 8'hF0, 0, 3, 0, 3));
    send_item(piece_item(0, -1, 8'hC0, 0, 3, 0, 3));
    send_item(piece_item(-300, 0, 8'h30, 0, 3, 0, 3));
  endtask

  // Coordinate extremes that wrap, and a piece hidden by its own source.
  task automatic test_field_extremes();
    send_item(piece_item(32767, -32768, 8'hFF, -32768, 32767, 32767, -32768));
    send_item(piece_item(32767, 32767, 8'h00, -32768, 32767, -32768, 32767));
    send_item(piece_item(10, 10, 8'h00, 20, 19, 0, 0));
  endtask

  // Area registers at their extremes, including a width with bit 15 set.
  task automatic test_area_extremes();
    set_area(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    run_frames(40, 1'b1);
    set_area(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
    run_frames(40, 1'b1);
    set_area(16'hFFF0, 16'h0010, 16'hFFFF, 16'h8001);
    run_frames(40, 1'b1);
  endtask

  // Random areas, each followed by random frames.
  task automatic test_random_frames();
    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 3))
        0: set_area(16'd0, 16'd0, 16'd320, 16'd200);
        1: set_area(16'($urandom_range(0, 200)) - 16'd100, 16'($urandom_range(0, 200)) - 16'd100,
                    16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)));
        2: set_area(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: set_area(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                          16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)));
      endcase
      run_frames(88, 1'b1);
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    set_area(16'd0, 16'd0, 16'd320, 16'd200);
    run_frames(60, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    gaps_on = 1'b1;
    test_piece_before_begin();
    test_frame_modes();
    test_empty_window();
    test_layer_offset();
    test_pict_extension();
    test_field_extremes();
    test_area_extremes();
    test_random_frames();
    test_steady_stream();
    drain();
    $display("covered %0d transactions in all four clip modes over %0d area settings,",
             items_sent, areas_used);
    $display("with %0d results checked and %0d bad", results_seen, bad_results);
    if (bad_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog in case the block stops answering.
  initial begin
    #5_000_000;
    $display("timeout with %0d results still owed", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/spcb_pkg.sv
sv/spcb_in_stage.sv
sv/spcb_axis_clip.sv
sv/sprite_piece_clip_and_bound_core.sv
tb/sprite_piece_clip_and_bound_core_tb.sv
